/* rtl/core/additive_sine_synth_with_lfos_unit_assert.svh */
// Assertion macros used by the synthesizer RTL.
`ifndef ADDITIVE_SINE_SYNTH_WITH_LFOS_UNIT_ASSERT_SVH
`define ADDITIVE_SINE_SYNTH_WITH_LFOS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/asl_pkg.sv */
package asl_pkg;

    // Default sizes.
    localparam int TABLE_SIZE = 1024;
    localparam int HARMONICS  = 16;

    // Fixed constants of the arithmetic.
    localparam logic [15:0] ENV_ONE  = 16'd32768;
    localparam int          TREM_MIX = 9830;

    // Configuration register reset values.
    localparam logic [25:0] BASE_STEP_RST  = 26'd28835840;
    localparam logic [25:0] LFO1_STEP_RST  = 26'd6554;
    localparam logic [15:0] LFO1_DEPTH_RST = 16'd4096;
    localparam logic [25:0] LFO2_STEP_RST  = 26'd6554;
    localparam logic [15:0] LFO2_DEPTH_RST = 16'd8192;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BASE_STEP  = 3'd0;
    localparam logic [2:0] CFG_LFO1_STEP  = 3'd1;
    localparam logic [2:0] CFG_LFO1_DEPTH = 3'd2;
    localparam logic [2:0] CFG_LFO2_STEP  = 3'd3;
    localparam logic [2:0] CFG_LFO2_DEPTH = 3'd4;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_GAIN,
        KIND_ENV
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

    // Source of a sine evaluation travelling down the sine pipeline.
    typedef enum logic [1:0] {
        SRC_COS,
        SRC_FUND,
        SRC_HARM
    } src_t;

    typedef struct packed {
        logic        valid;
        src_t        src;
        logic        last;
        logic [15:0] gain;
    } tag_t;

endpackage

/* rtl/core/asl_if.sv */
// Request channel: ticks and table loads.
interface asl_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] mix_in;
    logic [9:0]         entry_index;
    logic [15:0]        entry_value;

    modport source (output valid, kind, mix_in, entry_index, entry_value, input ready);
    modport sink   (input valid, kind, mix_in, entry_index, entry_value, output ready);
endinterface

// Result channel: one sample per tick.
interface asl_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

// Configuration write channel.
interface asl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [25:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/asl_ram.sv */
module asl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/asl_cell.sv */
module asl_cell #(
    parameter int PW = 26
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic [PW-1:0] phase_in,
    input  logic [15:0]   gain_in,
    input  logic          load,
    input  logic [15:0]   load_gain,
    output logic [PW-1:0] phase,
    output logic [15:0]   gain
);

    logic [PW-1:0] phase_reg;
    logic [15:0]   gain_reg;

    // One harmonic's phase and gain; the ring moves them one cell per shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            gain_reg  <= '0;
        end
        else if (shift)
        begin
            phase_reg <= phase_in;
            gain_reg  <= gain_in;
        end
        else if (load)
        begin
            gain_reg <= load_gain;
        end
    end

    assign phase = phase_reg;
    assign gain  = gain_reg;

endmodule

/* rtl/core/asl_sine.sv */
module asl_sine (
    input  logic               clk,
    input  logic               rst_n,
    input  asl_pkg::tag_t      tag_in,
    input  logic [16:0]        u_in,
    output asl_pkg::tag_t      tag_out,
    output logic signed [15:0] s_out
);

    asl_pkg::tag_t      tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic [1:0]         q1_reg, q2_reg, q3_reg, q4_reg;
    logic [15:0]        z1_reg, z2_reg, z3_reg, z4_reg;
    logic [15:0]        zz2_reg, zz3_reg;
    logic [15:0]        t2_reg;
    logic [15:0]        t4_reg;
    logic signed [15:0] s5_reg;

    logic [15:0] z_next;
    logic [31:0] m2, m3, m4, m5;
    logic [16:0] t1, t3, r5;
    logic [16:0] rc5;

    // Fold the angle into the first quadrant.
    always_comb
    begin
        if (u_in[15])
        begin
            z_next = 16'(17'd32768 - 17'(u_in[14:0]));
        end
        else
        begin
            z_next = 16'(u_in[14:0]);
        end
    end

    // Polynomial steps, one multiply per stage.
    always_comb
    begin
        m2 = 32'(z1_reg) * 32'(z1_reg);
        m3 = 32'(zz2_reg) * 32'(2320);
        t1 = m3[31:15];
        m4 = 32'(t2_reg) * 32'(zz3_reg);
        t3 = m4[31:15];
        m5 = 32'(t4_reg) * 32'(z4_reg);
        r5 = m5[31:15];
        rc5 = (r5 > 17'd32767) ? 17'd32767 : r5;
    end

    // Tags travel with the data; they carry the only control state here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        q1_reg  <= u_in[16:15];
        z1_reg  <= z_next;
        q2_reg  <= q1_reg;
        z2_reg  <= z1_reg;
        zz2_reg <= m2[30:15];
        q3_reg  <= q2_reg;
        z3_reg  <= z2_reg;
        zz3_reg <= zz2_reg;
        t2_reg  <= 16'(17'd21023 - t1);
        q4_reg  <= q3_reg;
        z4_reg  <= z3_reg;
        t4_reg  <= 16'(17'd51472 - t3);
        if (q4_reg[1])
        begin
            s5_reg <= -$signed(16'(rc5));
        end
        else
        begin
            s5_reg <= $signed(16'(rc5));
        end
    end

    assign tag_out = tag5_reg;
    assign s_out   = s5_reg;

endmodule

/* rtl/core/additive_sine_synth_with_lfos_unit.sv */
// Additive sine synthesizer with a tremolo LFO and a harmonic gain LFO.
// Requests arrive on req: kind 0 is a sample tick carrying mix_in, kind 1
// loads a harmonic gain, kind 2 loads an envelope entry; kind 3 is dropped.
// Only a tick yields a result, one sample on rsp. Registers are written on
// cfg at any time the block is idle; a zero write leaves a register as is.
// A tick issues one sine evaluation per cycle into the five-stage sine
// pipeline (gain LFO, fundamental, then each harmonic as the ring of
// harmonic cells rotates), followed by the weighting and a five-stage
// output chain. No new request is accepted until the tick's sample has
// reached the result register.
// A finished sample waits in a holding register behind the output register,
// so the next tick is accepted while rsp is stalled; a third tick waits for
// the holding register to drain. After reset the envelope memory is filled
// with unity gain, one entry a cycle over all TABLE_SIZE entries, during
// which no request is accepted; configuration writes are always taken.
`include "additive_sine_synth_with_lfos_unit_assert.svh"
module additive_sine_synth_with_lfos_unit #(
    parameter int TABLE_SIZE = asl_pkg::TABLE_SIZE,
    parameter int HARMONICS  = asl_pkg::HARMONICS
) (
    input logic        clk,
    input logic        rst_n,
    asl_req_if.sink    req,
    asl_rsp_if.source  rsp,
    asl_cfg_if.sink    cfg
);

    localparam int LOG2T = $clog2(TABLE_SIZE);
    localparam int PW    = LOG2T + 16;
    localparam int SH    = 17 - LOG2T;
    localparam int CW    = $clog2(HARMONICS + 3);
    localparam logic [CW-1:0] SLOT_COS  = CW'(0);
    localparam logic [CW-1:0] SLOT_FUND = CW'(1);
    localparam logic [CW-1:0] SLOT_LAST = CW'(HARMONICS + 1);
    localparam logic [CW-1:0] SLOT_DONE = CW'(HARMONICS + 2);

    // LFO term: 1.0 - depth + depth*square, all Q.15 with depth Q4.12.
    function automatic logic signed [20:0] lfo_term(input logic [15:0] depth,
                                                     input logic [15:0] sq);
        logic [31:0]        prod;
        logic signed [22:0] sum;
        prod = 32'(depth) * 32'(sq);
        sum  = 23'sd32768 - $signed(23'({depth, 3'b000})) + $signed(23'(prod[31:12]));
        return 21'(sum);
    endfunction

    // Table position to quarter-wave angle units.
    function automatic logic [16:0] turn(input logic [PW-1:0] ph);
        return 17'(ph[PW-1:16]) << SH;
    endfunction

    // Configuration registers.
    logic [25:0] base_step_reg, lfo1_step_reg, lfo2_step_reg;
    logic [15:0] lfo1_depth_reg, lfo2_depth_reg;

    // Control state.
    asl_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [LOG2T-1:0] clr_reg;
    logic [LOG2T-1:0] pos_reg;
    logic [PW-1:0]    fund_reg, trem_reg, glfo_reg, step_reg;
    logic [4:0]       ev_reg;
    logic             pend_reg;
    logic             out_v_reg;

    // Datapath registers.
    logic signed [16:0] tri_reg;
    logic [15:0]        tsq_reg, csq_reg;
    logic signed [20:0] lfo1_reg, lfo2_reg;
    logic signed [16:0] g_reg;
    logic               g_v_reg, g_last_reg;
    logic signed [22:0] hp_reg;
    logic               hp_v_reg, hp_last_reg;
    logic signed [31:0] buff_reg, buff_next;
    logic signed [31:0] mix_reg;
    logic signed [37:0] m1s_reg, m2s_reg;
    logic signed [38:0] acc_reg;
    logic signed [40:0] sc_reg;
    logic signed [31:0] res_reg, out_reg;

    // Request decode.
    logic acc_req, tick, gain_ld, env_ld, clearing, move;
    assign clearing = (state_reg == asl_pkg::ST_CLEAR);
    assign req.ready = (state_reg == asl_pkg::ST_IDLE) && !pend_reg;
    assign acc_req  = req.valid && req.ready;
    assign tick     = acc_req && (req.kind == asl_pkg::KIND_TICK);
    assign gain_ld  = acc_req && (req.kind == asl_pkg::KIND_GAIN)
                      && (32'(req.entry_index) < HARMONICS);
    assign env_ld   = acc_req && (req.kind == asl_pkg::KIND_ENV)
                      && (32'(req.entry_index) < TABLE_SIZE);
    assign cfg.ready = 1'b1;

    // Configuration writes; zero writes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg  <= asl_pkg::BASE_STEP_RST;
            lfo1_step_reg  <= asl_pkg::LFO1_STEP_RST;
            lfo1_depth_reg <= asl_pkg::LFO1_DEPTH_RST;
            lfo2_step_reg  <= asl_pkg::LFO2_STEP_RST;
            lfo2_depth_reg <= asl_pkg::LFO2_DEPTH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                asl_pkg::CFG_BASE_STEP:
                begin
                    if (cfg.data != '0) base_step_reg <= cfg.data;
                end
                asl_pkg::CFG_LFO1_STEP:
                begin
                    if (cfg.data != '0) lfo1_step_reg <= cfg.data;
                end
                asl_pkg::CFG_LFO1_DEPTH:
                begin
                    if (cfg.data[15:0] != '0) lfo1_depth_reg <= cfg.data[15:0];
                end
                asl_pkg::CFG_LFO2_STEP:
                begin
                    if (cfg.data != '0) lfo2_step_reg <= cfg.data;
                end
                asl_pkg::CFG_LFO2_DEPTH:
                begin
                    if (cfg.data[15:0] != '0) lfo2_depth_reg <= cfg.data[15:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Issue slots: gain LFO cosine, fundamental, then one harmonic each.
    logic slot_cos, slot_fund, slot_harm, issue;
    assign issue     = (state_reg == asl_pkg::ST_RUN) && (cnt_reg != SLOT_DONE);
    assign slot_cos  = issue && (cnt_reg == SLOT_COS);
    assign slot_fund = issue && (cnt_reg == SLOT_FUND);
    assign slot_harm = issue && (cnt_reg != SLOT_COS) && (cnt_reg != SLOT_FUND);

    // Ring of harmonic cells; cell 0 is the head that feeds the sine pipe.
    logic [PW-1:0] cell_phase [HARMONICS];
    logic [15:0]   cell_gain  [HARMONICS];
    logic [PW-1:0] head_upd;
    assign head_upd = PW'(cell_phase[0] + step_reg);

    for (genvar i = 0; i < HARMONICS; i++)
    begin : g_ring
        logic [PW-1:0] pin;
        logic [15:0]   gin;
        if (i == HARMONICS - 1)
        begin : g_tail
            assign pin = head_upd;
            assign gin = cell_gain[0];
        end
        else
        begin : g_mid
            assign pin = cell_phase[i+1];
            assign gin = cell_gain[i+1];
        end
        asl_cell #(.PW(PW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (slot_harm),
            .phase_in  (pin),
            .gain_in   (gin),
            .load      (gain_ld && (req.entry_index == 10'(i))),
            .load_gain (req.entry_value),
            .phase     (cell_phase[i]),
            .gain      (cell_gain[i])
        );
    end

    // Sine pipeline input.
    asl_pkg::tag_t      tag_in, tag_out;
    logic [16:0]        u_in;
    logic signed [15:0] s_out;

    always_comb
    begin
        tag_in.valid = issue;
        tag_in.last  = slot_harm && (cnt_reg == SLOT_LAST);
        tag_in.gain  = cell_gain[0];
        if (slot_cos)
        begin
            tag_in.src = asl_pkg::SRC_COS;
            u_in       = 17'(turn(glfo_reg) + 17'd32768);
        end
        else if (slot_fund)
        begin
            tag_in.src = asl_pkg::SRC_FUND;
            u_in       = turn(fund_reg);
        end
        else
        begin
            tag_in.src = asl_pkg::SRC_HARM;
            u_in       = turn(cell_phase[0]);
        end
    end

    asl_sine u_sine (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_in),
        .u_in    (u_in),
        .tag_out (tag_out),
        .s_out   (s_out)
    );

    // Envelope memory, filled with unity after reset.
    logic [15:0] env_rdata;
    asl_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_env (
        .clk   (clk),
        .we    (clearing || env_ld),
        .waddr (clearing ? clr_reg : LOG2T'(req.entry_index)),
        .wdata (clearing ? asl_pkg::ENV_ONE : req.entry_value),
        .re    (tick),
        .raddr (pos_reg),
        .rdata (env_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            asl_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1) state_next = asl_pkg::ST_IDLE;
            end
            asl_pkg::ST_IDLE:
            begin
                if (tick)
                begin
                    state_next = asl_pkg::ST_RUN;
                    cnt_next   = SLOT_COS;
                end
            end
            asl_pkg::ST_RUN:
            begin
                if (issue) cnt_next = cnt_reg + CW'(1);
                if (ev_reg[4]) state_next = asl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = asl_pkg::ST_IDLE;
            end
        endcase
    end

    logic sine_harm, sine_fund, sine_cos;
    assign sine_harm = tag_out.valid && (tag_out.src == asl_pkg::SRC_HARM);
    assign sine_fund = tag_out.valid && (tag_out.src == asl_pkg::SRC_FUND);
    assign sine_cos  = tag_out.valid && (tag_out.src == asl_pkg::SRC_COS);

    // Harmonic sum: fundamental plus each weighted harmonic.
    always_comb
    begin
        buff_next = buff_reg;
        if (tick)
        begin
            buff_next = '0;
        end
        else
        begin
            if (sine_fund) buff_next = buff_next + 32'(s_out);
            if (hp_v_reg)  buff_next = buff_next + 32'(hp_reg);
        end
    end

    assign move = pend_reg && (!out_v_reg || rsp.ready);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= asl_pkg::ST_CLEAR;
            cnt_reg     <= SLOT_DONE;
            clr_reg     <= '0;
            pos_reg     <= '0;
            fund_reg    <= '0;
            trem_reg    <= '0;
            glfo_reg    <= '0;
            ev_reg      <= '0;
            g_v_reg     <= 1'b0;
            g_last_reg  <= 1'b0;
            hp_v_reg    <= 1'b0;
            hp_last_reg <= 1'b0;
            pend_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (clearing) clr_reg <= clr_reg + LOG2T'(1);
            if (tick)
            begin
                pos_reg  <= (pos_reg == '1) ? LOG2T'(1) : pos_reg + LOG2T'(1);
                trem_reg <= PW'(trem_reg + PW'(lfo1_step_reg));
            end
            if (slot_cos)  glfo_reg <= PW'(glfo_reg + PW'(lfo2_step_reg));
            if (slot_fund) fund_reg <= PW'(fund_reg + PW'(base_step_reg));
            g_v_reg     <= sine_harm;
            g_last_reg  <= sine_harm && tag_out.last;
            hp_v_reg    <= g_v_reg;
            hp_last_reg <= g_last_reg;
            ev_reg      <= {ev_reg[3:0], hp_v_reg && hp_last_reg};
            if (ev_reg[4])
            begin
                pend_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_reg <= 1'b0;
            end
            if (move)
            begin
                out_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Harmonic step accumulator: (h+1) times the base step.
    always_ff @(posedge clk)
    begin
        if (slot_fund)
        begin
            step_reg <= PW'(base_step_reg);
        end
        else if (slot_harm)
        begin
            step_reg <= PW'(step_reg + PW'(base_step_reg));
        end
    end

    logic [17:0] v_t;
    logic [33:0] tsq_m, csq_m;
    logic signed [32:0] g_m;
    logic signed [37:0] hp_m;
    logic signed [52:0] m1_m, m2_m;
    logic signed [55:0] sc_m;

    always_comb
    begin
        v_t   = 18'(turn(trem_reg));
        tsq_m = 34'($signed(34'(tri_reg)) * $signed(34'(tri_reg)));
        csq_m = 34'($signed(34'(s_out)) * $signed(34'(s_out)));
        g_m   = 33'(s_out) * $signed(33'({1'b0, tag_out.gain}));
        hp_m  = 38'(g_reg) * 38'(lfo2_reg);
        m1_m  = 53'(buff_reg) * 53'(lfo1_reg);
        m2_m  = 53'(m1s_reg) * 53'sd9830;
        sc_m  = 56'(acc_reg) * $signed(56'({1'b0, env_rdata}));
    end

    // LFO terms, harmonic weighting and the output chain.
    always_ff @(posedge clk)
    begin
        buff_reg <= buff_next;
        if (tick)
        begin
            mix_reg <= req.mix_in;
            if (v_t < 18'd65536)
            begin
                tri_reg <= 17'($signed(v_t) - 18'sd32768);
            end
            else
            begin
                tri_reg <= 17'(18'sd98304 - $signed(v_t));
            end
        end
        tsq_reg  <= tsq_m[30:15];
        lfo1_reg <= lfo_term(lfo1_depth_reg, tsq_reg);
        if (sine_cos) csq_reg <= csq_m[30:15];
        lfo2_reg <= lfo_term(lfo2_depth_reg, csq_reg);
        g_reg    <= g_m[32:16];
        hp_reg   <= hp_m[37:15];
        m1s_reg  <= m1_m[52:15];
        m2s_reg  <= m2_m[52:15];
        acc_reg  <= 39'(mix_reg) + 39'(buff_reg) + 39'(m2s_reg);
        sc_reg   <= sc_m[55:15];
        if (ev_reg[4])
        begin
            if (sc_reg > 41'sd2147483647)
            begin
                res_reg <= 32'sh7FFFFFFF;
            end
            else if (sc_reg < -41'sd2147483648)
            begin
                res_reg <= 32'sh80000000;
            end
            else
            begin
                res_reg <= 32'(sc_reg);
            end
        end
        if (move) out_reg <= res_reg;
    end

    assign rsp.valid  = out_v_reg;
    assign rsp.sample = out_reg;

    // A new result never lands on one still waiting.
    `ASL_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, ev_reg[4], !pend_reg)
    // A waiting result stays while the output is stalled.
    `ASL_ASSERT_NEXT(a_pend_holds, clk, rst_n, pend_reg && out_v_reg && !rsp.ready, pend_reg)
    // Sine results only appear while a tick is in progress.
    `ASL_ASSERT_IMPLY(a_sine_in_run, clk, rst_n, tag_out.valid, state_reg == asl_pkg::ST_RUN)
    // The output chain starts only after every slot was issued.
    `ASL_ASSERT_IMPLY(a_issue_done, clk, rst_n, ev_reg[0], cnt_reg == SLOT_DONE)

endmodule

/* tb/additive_sine_synth_with_lfos_unit_tb.sv */
module additive_sine_synth_with_lfos_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TSIZE = asl_pkg::TABLE_SIZE;
    localparam int NHARM = asl_pkg::HARMONICS;
    localparam longint PMOD = longint'(TSIZE) << 16;
    localparam int SETTLE = NHARM + 40;
    localparam int HOLD_CYCLES = 150;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;

    asl_req_if req ();
    asl_rsp_if rsp ();
    asl_cfg_if cfg ();

    additive_sine_synth_with_lfos_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // Shadow of the synthesizer configuration and state.
    longint step_fund, step_trem, depth_trem, step_glfo, depth_glfo;
    longint ph_fund, ph_trem, ph_glfo;
    longint ph_harm [NHARM];
    longint gain_harm [NHARM];
    longint env_mem [TSIZE];
    int     env_pos;

    logic signed [31:0] sample_queue [$];
    int  mismatches = 0;
    bit  hold_rx;
    bit  hold_seen;
    int  stall_left;
    bit  calm;
    longint cycles = 0;

    // Clock and cycle watchdog.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("additive_sine_synth_with_lfos_unit_tb NOT OK");
            $finish;
        end
    end

    // Floor shift of a signed value, rounding towards minus infinity.
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint units_of(longint idx);
        return (idx << 17) / TSIZE;
    endfunction

    // Polynomial sine in Q15 from a turn measured in 131072 units.
    function automatic longint poly_sine(longint u);
        int quad;
        longint f, z, z2, t, r;
        quad = int'((u >> 15) & 3);
        f = u & 32767;
        z = quad[0] ? 32768 - f : f;
        z2 = (z * z) >> 15;
        t = (2320 * z2) >> 15;
        t = 21023 - t;
        t = (t * z2) >> 15;
        t = 51472 - t;
        r = (t * z) >> 15;
        if (r > 32767)
            r = 32767;
        return quad[1] ? -r : r;
    endfunction

    function automatic longint lfo_gain(longint depth, longint sq);
        return 32768 - depth * 8 + ((depth * sq) >>> 12);
    endfunction

    function automatic void reset_shadow();
        step_fund = longint'(asl_pkg::BASE_STEP_RST);
        step_trem = longint'(asl_pkg::LFO1_STEP_RST);
        depth_trem = longint'(asl_pkg::LFO1_DEPTH_RST);
        step_glfo = longint'(asl_pkg::LFO2_STEP_RST);
        depth_glfo = longint'(asl_pkg::LFO2_DEPTH_RST);
        ph_fund = 0;
        ph_trem = 0;
        ph_glfo = 0;
        foreach (ph_harm[h])
        begin
            ph_harm[h] = 0;
            gain_harm[h] = 0;
        end
        foreach (env_mem[i])
            env_mem[i] = longint'(asl_pkg::ENV_ONE);
        env_pos = 0;
    endfunction

    // Next sample of a tick; advances every phase and the envelope position.
    function automatic logic signed [31:0] synth_sample(logic signed [31:0] mix);
        longint trem, glfo, buff, acc, res, c, v, tri_v, s, g;
        v = units_of(ph_trem >> 16);
        tri_v = (v < 65536) ? v - 32768 : 98304 - v;
        trem = lfo_gain(depth_trem, (tri_v * tri_v) >> 15);
        ph_trem = (ph_trem + step_trem) % PMOD;
        c = poly_sine((units_of(ph_glfo >> 16) + 32768) & 131071);
        glfo = lfo_gain(depth_glfo, (c * c) >> 15);
        ph_glfo = (ph_glfo + step_glfo) % PMOD;
        buff = poly_sine(units_of(ph_fund >> 16));
        ph_fund = (ph_fund + step_fund) % PMOD;
        for (int h = 0; h < NHARM; h++)
        begin
            s = poly_sine(units_of(ph_harm[h] >> 16));
            g = fshr(s * gain_harm[h], 16);
            buff += fshr(g * glfo, 15);
            ph_harm[h] = (ph_harm[h] + step_fund * (h + 1)) % PMOD;
        end
        acc = longint'(mix) + buff
              + fshr(fshr(buff * trem, 15) * longint'(asl_pkg::TREM_MIX), 15);
        res = fshr(acc * env_mem[env_pos], 15);
        env_pos++;
        if (env_pos >= TSIZE)
            env_pos = 1;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[31:0];
    endfunction

    // Random gap on the request side, none during calm stretches.
    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 12)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 12)
                @(posedge clk);
        end
    endtask

    // Send one request and update the shadow state when it is taken.
    task automatic send_request(logic [1:0] kind, logic signed [31:0] mix,
                                logic [9:0] idx, logic [15:0] val);
        maybe_idle();
        req.valid <= 1'b1;
        req.kind <= kind;
        req.mix_in <= mix;
        req.entry_index <= idx;
        req.entry_value <= val;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        case (kind)
            asl_pkg::KIND_TICK: sample_queue.push_back(synth_sample(mix));
            asl_pkg::KIND_GAIN: if (idx < NHARM) gain_harm[idx] = longint'(val);
            asl_pkg::KIND_ENV:  env_mem[idx] = longint'(val);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (sample_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write; only issued once the block is idle.
    task automatic write_reg(logic [2:0] index, logic [25:0] data);
        longint v26, v16;
        wait_idle();
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        v26 = longint'(data);
        v16 = longint'(data[15:0]);
        case (index)
            asl_pkg::CFG_BASE_STEP:  if (v26 != 0) step_fund = v26;
            asl_pkg::CFG_LFO1_STEP:  if (v26 != 0) step_trem = v26;
            asl_pkg::CFG_LFO1_DEPTH: if (v16 != 0) depth_trem = v16;
            asl_pkg::CFG_LFO2_STEP:  if (v26 != 0) step_glfo = v26;
            asl_pkg::CFG_LFO2_DEPTH: if (v16 != 0) depth_glfo = v16;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_mix();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom_range(65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls, one long stall per hold window, and
    // comparison with the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_left <= 0;
            hold_seen <= 1'b0;
        end
        else
        begin
            hold_seen <= hold_rx;
            if (hold_rx && !hold_seen)
            begin
                rsp.ready <= 1'b0;
                stall_left <= HOLD_CYCLES;
            end
            else if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
                rsp.ready <= calm || ($urandom_range(99) >= 12);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (sample_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %0d", rsp.sample);
            end
            else if (rsp.sample !== sample_queue[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sample mismatch: expected %0d actual %0d",
                             sample_queue[0], rsp.sample);
                void'(sample_queue.pop_front());
            end
            else
                void'(sample_queue.pop_front());
        end
    end

    task automatic test_directed();
        send_request(asl_pkg::KIND_TICK, 0, 10'd0, 16'd0);
        send_request(asl_pkg::KIND_GAIN, 0, 10'd0, 16'hFFFF);
        send_request(asl_pkg::KIND_GAIN, 0, 10'(NHARM - 1), 16'h8000);
        send_request(asl_pkg::KIND_GAIN, 0, 10'h3FF, 16'h1234);
        send_request(asl_pkg::KIND_GAIN, 0, 10'(NHARM), 16'h5555);
        send_request(asl_pkg::KIND_ENV, 0, 10'd0, 16'hFFFF);
        send_request(asl_pkg::KIND_ENV, 0, 10'h3FF, 16'h0000);
        send_request(asl_pkg::KIND_ENV, 0, 10'd1, 16'h7FFF);
        send_request(2'd3, 32'sh7FFFFFFF, 10'h3FF, 16'hFFFF);
        send_request(asl_pkg::KIND_TICK, 32'sh7FFFFFFF, 10'd0, 16'd0);
        send_request(asl_pkg::KIND_TICK, 32'sh80000000, 10'h3FF, 16'hFFFF);
        send_request(asl_pkg::KIND_TICK, -1, 10'd0, 16'd0);
        send_request(asl_pkg::KIND_TICK, 12345, 10'd0, 16'd0);
    endtask

    // Long run of ticks; with the ticks of the later tests the envelope
    // position goes all the way round and wraps.
    task automatic test_envelope_wrap();
        for (int i = 0; i < 860; i++)
            send_request(asl_pkg::KIND_TICK, (i % 7 == 0) ? 32'sh7FFF0000 : $urandom,
                         10'd0, 16'd0);
    endtask

    task automatic test_register_extremes();
        write_reg(asl_pkg::CFG_BASE_STEP, 26'h3FFFFFF);
        write_reg(asl_pkg::CFG_LFO1_STEP, 26'd1);
        write_reg(asl_pkg::CFG_LFO1_DEPTH, 26'hFFFF);
        write_reg(asl_pkg::CFG_LFO2_STEP, 26'h3FFFFFF);
        write_reg(asl_pkg::CFG_LFO2_DEPTH, 26'd1);
        for (int i = 0; i < 40; i++)
            send_request(asl_pkg::KIND_TICK, rand_mix(), 10'd0, 16'd0);
        write_reg(asl_pkg::CFG_BASE_STEP, 26'd0);
        write_reg(asl_pkg::CFG_LFO1_DEPTH, 26'h3FF0000);
        write_reg(asl_pkg::CFG_BASE_STEP, 26'd1);
        write_reg(asl_pkg::CFG_LFO1_STEP, 26'h3FFFFFF);
        write_reg(asl_pkg::CFG_LFO2_STEP, 26'd1);
        write_reg(asl_pkg::CFG_LFO2_DEPTH, 26'hFFFF);
        write_reg(asl_pkg::CFG_LFO1_DEPTH, 26'd1);
        for (int i = 0; i < 40; i++)
            send_request(asl_pkg::KIND_TICK, rand_mix(), 10'd0, 16'd0);
    endtask

    // Random mix of ticks and loads over several register settings.
    task automatic test_random();
        logic [1:0] kind;
        logic [9:0] idx;
        for (int phase_n = 0; phase_n < 4; phase_n++)
        begin
            write_reg(asl_pkg::CFG_BASE_STEP, 26'($urandom));
            write_reg(asl_pkg::CFG_LFO1_STEP, 26'($urandom_range(200000, 1)));
            write_reg(asl_pkg::CFG_LFO1_DEPTH, 26'($urandom));
            write_reg(asl_pkg::CFG_LFO2_STEP, 26'($urandom));
            write_reg(asl_pkg::CFG_LFO2_DEPTH, 26'($urandom_range(16384, 1)));
            for (int i = 0; i < 50; i++)
            begin
                calm = (i >= 15 && i < 35);
                hold_rx = (i >= 40 && i < 45);
                case ($urandom_range(9))
                    0, 1: kind = asl_pkg::KIND_GAIN;
                    2:    kind = asl_pkg::KIND_ENV;
                    3:    kind = 2'd3;
                    default: kind = asl_pkg::KIND_TICK;
                endcase
                idx = (kind == asl_pkg::KIND_GAIN && $urandom_range(3) != 0)
                    ? 10'($urandom_range(NHARM - 1)) : 10'($urandom);
                send_request(kind, rand_mix(), idx, 16'($urandom));
            end
            calm = 1'b0;
            hold_rx = 1'b0;
        end
    endtask

    initial
    begin
        int waited;
        hold_rx = 1'b0;
        calm = 1'b0;
        req.valid = 1'b0;
        req.kind = asl_pkg::KIND_TICK;
        req.mix_in = 0;
        req.entry_index = 10'd0;
        req.entry_value = 16'd0;
        cfg.valid = 1'b0;
        cfg.index = asl_pkg::CFG_BASE_STEP;
        cfg.data = 26'd0;
        reset_shadow();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_envelope_wrap();
        test_register_extremes();
        test_random();

        req.valid <= 1'b0;
        waited = 0;
        while (sample_queue.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && sample_queue.size() == 0)
            $display("additive_sine_synth_with_lfos_unit_tb OK");
        else
            $display("additive_sine_synth_with_lfos_unit_tb NOT OK");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/asl_pkg.sv
rtl/core/asl_if.sv
rtl/core/asl_ram.sv
rtl/core/asl_cell.sv
rtl/core/asl_sine.sv
rtl/core/additive_sine_synth_with_lfos_unit.sv
tb/additive_sine_synth_with_lfos_unit_tb.sv
